### sv/u8id_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package u8id_pkg;

    localparam int COUNT_WIDTH = 16;

    // scan phase codes
    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_CONT  = 2'd1;
    localparam logic [1:0] PH_STOP  = 2'd2;

    // allowed range of the next continuation byte
    localparam logic [2:0] CLS_NONE = 3'd0;
    localparam logic [2:0] CLS_ANY  = 3'd1;
    localparam logic [2:0] CLS_E0   = 3'd2;
    localparam logic [2:0] CLS_ED   = 3'd3;
    localparam logic [2:0] CLS_F0   = 3'd4;
    localparam logic [2:0] CLS_F4   = 3'd5;

    typedef struct packed {
        logic [1:0]             phase;
        logic [2:0]             lead_class;
        logic [1:0]             remaining;
        logic [2:0]             seq_bytes;
        logic [COUNT_WIDTH-1:0] count;
    } scan_state_t;

    localparam scan_state_t SCAN_START = '{
        phase:      PH_START,
        lead_class: CLS_NONE,
        remaining:  2'd0,
        seq_bytes:  3'd0,
        count:      '0
    };

endpackage

`default_nettype wire

### sv/utf8_identifier_scanner_unit.sv
// UTF-8 identifier scanner.
// Input channel: in_valid / in_stall carry one byte of a text (data_byte) a
// request, with final_byte marking its last byte. Output channel: out_valid /
// out_stall carry one result per text (found, matched_length), produced only
// for the final byte.
// Throughput: one byte per cycle unless in_stall is high. Each byte is
// decoded by a single level of compare and saturating add logic against the
// scan state registers. The result is shown in the cycle after the final
// byte is taken and held in an output register until the receiver takes it.
// Stalls: while a result waits and out_stall is high, in_stall is raised; as
// soon as the result is taken the next byte is accepted in the same cycle.
// hash_allowed is written through cfg_write / cfg_data and keeps its value
// across texts. Write it between texts only; the block does not enforce it.
// Reset: clears hash_allowed, the scan state (first codepoint expected, count
// zero) and the output valid flag. After each final byte the scan state
// returns to its start value for the next text.
`timescale 1ns / 1ps
`default_nettype none

module utf8_identifier_scanner_unit
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic                             cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [7:0]                       data_byte,
    input  wire logic                             final_byte,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic                                  found,
    output logic [u8id_pkg::COUNT_WIDTH-1:0]      matched_length
);

    logic                                 hash_allowed_reg;
    u8id_pkg::scan_state_t                state_reg;
    u8id_pkg::scan_state_t                state_next;
    logic                                 out_valid_reg;
    logic                                 found_reg;
    logic [u8id_pkg::COUNT_WIDTH-1:0]     length_reg;
    logic                                 in_take;

    assign in_stall = out_valid_reg && out_stall;
    assign in_take  = in_valid && !in_stall;

    u8id_decode u_decode
    (
        .cur          (state_reg),
        .data_byte    (data_byte),
        .hash_allowed (hash_allowed_reg),
        .nxt          (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_allowed_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            hash_allowed_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= u8id_pkg::SCAN_START;
        end
        else if (in_take)
        begin
            // back to start after the last byte of a text
            state_reg <= final_byte ? u8id_pkg::SCAN_START : state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_take && final_byte)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take && final_byte)
        begin
            found_reg  <= state_next.count != '0;
            length_reg <= state_next.count;
        end
    end

    assign out_valid      = out_valid_reg;
    assign found          = found_reg;
    assign matched_length = length_reg;

    a_final_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && final_byte |=> out_valid_reg)
        else $error("final byte accepted without a result");

    a_found_matches_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (found_reg == (length_reg != '0)))
        else $error("found flag disagrees with length");

    a_restart_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && final_byte |=>
            state_reg.count == '0 && state_reg.phase == u8id_pkg::PH_START)
        else $error("scan state not restarted after final byte");

    a_seq_covers_remaining: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.remaining != 2'd0 |->
            ({1'b0, state_reg.remaining} < state_reg.seq_bytes &&
             state_reg.phase != u8id_pkg::PH_STOP))
        else $error("pending sequence inconsistent with scan state");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg)
        else $error("input stalled with empty output register");

endmodule

`default_nettype wire

### sv/u8id_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module u8id_decode
(
    input  wire u8id_pkg::scan_state_t cur,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  hash_allowed,
    output u8id_pkg::scan_state_t      nxt
);

    localparam int CW = u8id_pkg::COUNT_WIDTH;

    logic          is_letter;
    logic          is_digit;
    logic          ascii_ok;
    logic          cont_ok;
    logic [1:0]    rem_dec;
    logic [CW:0]   sum_one;
    logic [CW:0]   sum_seq;
    logic [CW-1:0] count_one;
    logic [CW-1:0] count_seq;

    assign is_letter = (data_byte >= 8'h41 && data_byte <= 8'h5A) ||
                       (data_byte >= 8'h61 && data_byte <= 8'h7A);
    assign is_digit  = data_byte >= 8'h30 && data_byte <= 8'h39;

    always_comb
    begin
        if (cur.phase == u8id_pkg::PH_START)
        begin
            ascii_ok = (data_byte == 8'h5F) || is_letter;
        end
        else
        begin
            ascii_ok = (data_byte == 8'h5F) || is_letter || is_digit ||
                       (hash_allowed && data_byte == 8'h23);
        end
    end

    always_comb
    begin
        unique case (cur.lead_class)
            u8id_pkg::CLS_E0: cont_ok = data_byte >= 8'hA0 && data_byte <= 8'hBF;
            u8id_pkg::CLS_ED: cont_ok = data_byte >= 8'h80 && data_byte <= 8'h9F;
            u8id_pkg::CLS_F0: cont_ok = data_byte >= 8'h90 && data_byte <= 8'hBF;
            u8id_pkg::CLS_F4: cont_ok = data_byte >= 8'h80 && data_byte <= 8'h8F;
            default:          cont_ok = data_byte[7:6] == 2'b10;
        endcase
    end

    // saturating adds: one ASCII byte, or a whole multi-byte sequence
    assign sum_one   = {1'b0, cur.count} + {{CW{1'b0}}, 1'b1};
    assign sum_seq   = {1'b0, cur.count} + {{(CW-2){1'b0}}, cur.seq_bytes};
    assign count_one = sum_one[CW] ? {CW{1'b1}} : sum_one[CW-1:0];
    assign count_seq = sum_seq[CW] ? {CW{1'b1}} : sum_seq[CW-1:0];
    assign rem_dec   = cur.remaining - 2'd1;

    always_comb
    begin
        nxt = cur;
        if (cur.phase == u8id_pkg::PH_START || cur.phase == u8id_pkg::PH_CONT)
        begin
            if (cur.remaining == 2'd0)
            begin
                priority if (!data_byte[7])
                begin
                    if (ascii_ok)
                    begin
                        nxt.count = count_one;
                        nxt.phase = u8id_pkg::PH_CONT;
                    end
                    else
                    begin
                        nxt       = u8id_pkg::SCAN_START;
                        nxt.phase = u8id_pkg::PH_STOP;
                        nxt.count = cur.count;
                    end
                end
                else if (data_byte >= 8'hC2 && data_byte <= 8'hDF)
                begin
                    nxt.lead_class = u8id_pkg::CLS_ANY;
                    nxt.remaining  = 2'd1;
                    nxt.seq_bytes  = 3'd2;
                end
                else if (data_byte >= 8'hE0 && data_byte <= 8'hEF)
                begin
                    nxt.lead_class = (data_byte == 8'hE0) ? u8id_pkg::CLS_E0 :
                                     (data_byte == 8'hED) ? u8id_pkg::CLS_ED :
                                                            u8id_pkg::CLS_ANY;
                    nxt.remaining  = 2'd2;
                    nxt.seq_bytes  = 3'd3;
                end
                else if (data_byte >= 8'hF0 && data_byte <= 8'hF4)
                begin
                    nxt.lead_class = (data_byte == 8'hF0) ? u8id_pkg::CLS_F0 :
                                     (data_byte == 8'hF4) ? u8id_pkg::CLS_F4 :
                                                            u8id_pkg::CLS_ANY;
                    nxt.remaining  = 2'd3;
                    nxt.seq_bytes  = 3'd4;
                end
                else
                begin
                    nxt       = u8id_pkg::SCAN_START;
                    nxt.phase = u8id_pkg::PH_STOP;
                    nxt.count = cur.count;
                end
            end
            else if (cont_ok)
            begin
                nxt.remaining  = rem_dec;
                nxt.lead_class = u8id_pkg::CLS_ANY;
                if (rem_dec == 2'd0)
                begin
                    // sequence complete: every well-formed codepoint counts
                    nxt       = u8id_pkg::SCAN_START;
                    nxt.phase = u8id_pkg::PH_CONT;
                    nxt.count = count_seq;
                end
            end
            else
            begin
                nxt       = u8id_pkg::SCAN_START;
                nxt.phase = u8id_pkg::PH_STOP;
                nxt.count = cur.count;
            end
        end
    end

endmodule

`default_nettype wire
